@@ hdl/heapsort_engine_top_defines.svh @@
// Assertion macros for the heapsort engine.
// Define SYNTH to compile them away.
`ifndef HEAPSORT_ENGINE_TOP_DEFINES_SVH
`define HEAPSORT_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define HSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heapsort engine: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define HSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heapsort engine: next-cycle check failed");
`else
`define HSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/hse_pkg.sv @@
`timescale 1ns / 1ps

package hse_pkg;

    localparam int HSE_MAX_ITEMS  = 1024;
    localparam int HSE_DATA_WIDTH = 32;
    localparam int VALUE_WIDTH    = 32;

    // Input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] sorted_value;
        logic                   last_out;
        logic                   empty_res;
        logic                   overflow;
    } t_out_item;

endpackage

@@ hdl/heapsort_engine_top.sv @@
// Heapsort engine. Load items (kind = load) store one value each; the load
// with last set ends the set and starts an in-place max-heap heapsort over
// the data memory, after which each fetch item returns the next value in
// ascending order, with last_out on the final one. A fetch before the sort
// finishes or after the final value returns empty_res. Loads past MAX_ITEMS
// are dropped and reported through the overflow field of later fetches; the
// first load after a sorted set starts a new set. A fetch may wait on the
// output register. The sort runs on the single read port of the data
// memory: each sift-down level reads the left child, reads the right
// child, then compares and writes back, and the input stays not ready
// while the sort runs. The data memory needs no clearing pass after reset.
`timescale 1ns / 1ps
`include "heapsort_engine_top_defines.svh"

module heapsort_engine_top import hse_pkg::*; #(
    parameter int MAX_ITEMS  = HSE_MAX_ITEMS,
    parameter int DATA_WIDTH = HSE_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(MAX_ITEMS);      // memory address bits
    localparam int CW = $clog2(MAX_ITEMS + 1);  // counts and 1-based heap positions
    localparam int PW = CW + 1;                 // child positions, up to 2 * MAX_ITEMS
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_START,
        S_EVEN_A,
        S_EVEN_B,
        S_EVEN_C,
        S_EVEN_D,
        S_BUILD,
        S_SIFT_LD,
        S_SIFT_CHK,
        S_SIFT_L,
        S_SIFT_R,
        S_DOWN,
        S_DOWN_B,
        S_DOWN_C
    } t_state;

    t_state r_state;

    // Set bookkeeping
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_ptr;
    logic          r_sorted;
    logic          r_ovf;

    // Sort sequencer
    logic [CW-1:0]         r_hs;      // heap size
    logic [CW-1:0]         r_k;       // next build root
    logic [CW-1:0]         r_pos;     // sift position
    logic [CW-1:0]         r_c;       // left child position
    logic                  r_has_r;   // right child exists
    logic                  r_even;    // one element held back from the build
    logic                  r_build;   // sift belongs to the build phase
    logic [DATA_WIDTH-1:0] r_val;     // value being sifted
    logic [DATA_WIDTH-1:0] r_top;     // popped top or held compare value
    logic [DATA_WIDTH-1:0] r_lval;    // left child value

    // Fetch result
    logic      r_hit;
    logic      r_last;
    logic      r_out_valid;
    t_out_item r_out_item;

    // Memory port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    hse_ram #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Handshake
    logic in_acc;
    logic is_load;
    logic out_free;
    logic last_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign is_load     = (i_in_item.kind == KIND_LOAD);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign last_acc    = in_acc && is_load && i_in_item.last;

    // Load and fetch decode
    logic [CW-1:0]         eff_cnt;
    logic                  room;
    logic                  hit;
    logic [CW-1:0]         rd_ptr_p1;
    logic [DATA_WIDTH-1:0] load_val;

    assign eff_cnt   = r_sorted ? '0 : r_count;
    assign room      = (eff_cnt < MAX_CNT);
    assign hit       = r_sorted && (r_rd_ptr < r_count);
    assign rd_ptr_p1 = r_rd_ptr + CW'(1);
    assign load_val  = DATA_WIDTH'(64'(i_in_item.value));

    // Index arithmetic for the sort
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] pi_idx;
    logic [CW-1:0] k_m1;
    logic [CW-1:0] hs_m1;
    logic [CW-1:0] pos_m1;
    logic [PW-1:0] c_pos;
    logic [PW-1:0] c_m1;
    logic          c_out;       // no child inside the heap
    logic          pick_r;
    logic [DATA_WIDTH-1:0] best;
    logic [CW-1:0]         best_pos;
    logic                  move;

    assign cnt_m1   = r_count - CW'(1);
    assign pi_idx   = cnt_m1 >> 1;
    assign k_m1     = r_k - CW'(1);
    assign hs_m1    = r_hs - CW'(1);
    assign pos_m1   = r_pos - CW'(1);
    assign c_pos    = {r_pos, 1'b0};
    assign c_m1     = c_pos - PW'(1);
    assign c_out    = (c_pos > {1'b0, r_hs});
    assign pick_r   = r_has_r && (r_lval < mem_rdata);
    assign best     = pick_r ? mem_rdata : r_lval;
    assign best_pos = r_c + CW'(pick_r);
    assign move     = (r_val < best);

    // Memory port drive: at most one access per cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_load && room) begin
                    mem_we    = 1'b1;
                    mem_waddr = eff_cnt[AW-1:0];
                    mem_wdata = load_val;
                end
                if (in_acc && !is_load && hit) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd_ptr[AW-1:0];
                end
            end
            S_EVEN_A: begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1[AW-1:0];
            end
            S_EVEN_B: begin
                mem_re    = 1'b1;
                mem_raddr = pi_idx[AW-1:0];
            end
            S_EVEN_C: begin
                // parent smaller than last: last takes the parent value
                mem_we    = (mem_rdata < r_top);
                mem_waddr = cnt_m1[AW-1:0];
                mem_wdata = mem_rdata;
            end
            S_EVEN_D: begin
                mem_we    = 1'b1;
                mem_waddr = pi_idx[AW-1:0];
                mem_wdata = r_top;
            end
            S_BUILD: begin
                mem_re    = (r_k != '0);
                mem_raddr = k_m1[AW-1:0];
            end
            S_DOWN: begin
                mem_re    = (r_hs > CW'(1));
                mem_raddr = '0;
            end
            S_DOWN_B: begin
                mem_re    = 1'b1;
                mem_raddr = hs_m1[AW-1:0];
            end
            S_DOWN_C: begin
                // popped top goes just past the shrunken heap
                mem_we    = 1'b1;
                mem_waddr = hs_m1[AW-1:0];
                mem_wdata = r_top;
            end
            S_SIFT_CHK: begin
                if (c_out) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_m1[AW-1:0];
                    mem_wdata = r_val;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = c_m1[AW-1:0];
                end
            end
            S_SIFT_L: begin
                mem_re    = r_has_r;
                mem_raddr = r_c[AW-1:0];
            end
            S_SIFT_R: begin
                mem_we    = 1'b1;
                mem_waddr = pos_m1[AW-1:0];
                mem_wdata = move ? best : r_val;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_ptr    <= '0;
            r_sorted    <= 1'b0;
            r_ovf       <= 1'b0;
            r_hs        <= '0;
            r_k         <= '0;
            r_pos       <= '0;
            r_c         <= '0;
            r_has_r     <= 1'b0;
            r_even      <= 1'b0;
            r_build     <= 1'b0;
            r_hit       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output item once taken; the fetch state refills it itself
            if (r_out_valid && i_out_ready && (r_state != S_FETCH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && is_load) begin
                        // a load after a sorted set opens a new set
                        r_sorted <= 1'b0;
                        r_rd_ptr <= r_sorted ? '0 : r_rd_ptr;
                        r_hs     <= r_sorted ? '0 : r_hs;
                        r_ovf    <= (r_sorted ? 1'b0 : r_ovf) | !room;
                        r_count  <= room ? (eff_cnt + CW'(1)) : eff_cnt;
                        if (i_in_item.last) begin
                            r_state <= S_START;
                        end
                    end else if (in_acc) begin
                        r_hit  <= hit;
                        r_last <= (rd_ptr_p1 == r_count);
                        if (hit) begin
                            r_rd_ptr <= rd_ptr_p1;
                        end
                        r_state <= S_FETCH;
                    end
                end

                S_FETCH: begin
                    // hold the read data until the output register frees up
                    if (out_free) begin
                        r_out_valid             <= 1'b1;
                        r_out_item.sorted_value <= r_hit ? VALUE_WIDTH'(64'(mem_rdata)) : '0;
                        r_out_item.last_out     <= r_hit && r_last;
                        r_out_item.empty_res    <= !r_hit;
                        r_out_item.overflow     <= r_ovf;
                        r_state                 <= S_IDLE;
                    end
                end

                S_START: begin
                    r_build <= 1'b0;
                    if (r_count < CW'(2)) begin
                        r_sorted <= 1'b1;
                        r_rd_ptr <= '0;
                        r_state  <= S_IDLE;
                    end else if (!r_count[0]) begin
                        r_even  <= 1'b1;
                        r_state <= S_EVEN_A;
                    end else begin
                        r_even  <= 1'b0;
                        r_hs    <= r_count;
                        r_k     <= r_count >> 1;
                        r_state <= S_BUILD;
                    end
                end

                S_EVEN_A: begin
                    r_state <= S_EVEN_B;
                end

                S_EVEN_B: begin
                    r_top   <= mem_rdata;          // last element
                    r_state <= S_EVEN_C;
                end

                S_EVEN_C: begin
                    // build over the odd-sized prefix
                    r_hs    <= cnt_m1;
                    r_k     <= cnt_m1 >> 1;
                    r_state <= (mem_rdata < r_top) ? S_EVEN_D : S_BUILD;
                end

                S_EVEN_D: begin
                    r_state <= S_BUILD;
                end

                S_BUILD: begin
                    if (r_k == '0) begin
                        r_build <= 1'b0;
                        // the held-back element enters through one extra pop
                        if (r_even) begin
                            r_hs <= r_hs + CW'(1);
                        end
                        r_state <= S_DOWN;
                    end else begin
                        r_pos   <= r_k;
                        r_build <= 1'b1;
                        r_state <= S_SIFT_LD;
                    end
                end

                S_SIFT_LD: begin
                    r_val   <= mem_rdata;
                    r_state <= S_SIFT_CHK;
                end

                S_SIFT_CHK: begin
                    if (c_out) begin
                        if (r_build) begin
                            r_k     <= k_m1;
                            r_state <= S_BUILD;
                        end else begin
                            r_state <= S_DOWN;
                        end
                    end else begin
                        r_c     <= c_pos[CW-1:0];
                        r_has_r <= (c_pos < {1'b0, r_hs});
                        r_state <= S_SIFT_L;
                    end
                end

                S_SIFT_L: begin
                    r_lval  <= mem_rdata;
                    r_state <= S_SIFT_R;
                end

                S_SIFT_R: begin
                    if (move) begin
                        r_pos   <= best_pos;
                        r_state <= S_SIFT_CHK;
                    end else if (r_build) begin
                        r_k     <= k_m1;
                        r_state <= S_BUILD;
                    end else begin
                        r_state <= S_DOWN;
                    end
                end

                S_DOWN: begin
                    if (r_hs > CW'(1)) begin
                        r_state <= S_DOWN_B;
                    end else begin
                        r_sorted <= 1'b1;
                        r_rd_ptr <= '0;
                        r_state  <= S_IDLE;
                    end
                end

                S_DOWN_B: begin
                    r_top   <= mem_rdata;          // heap top
                    r_state <= S_DOWN_C;
                end

                S_DOWN_C: begin
                    r_val   <= mem_rdata;          // last heap element, sift from the root
                    r_hs    <= hs_m1;
                    r_pos   <= CW'(1);
                    r_state <= S_SIFT_CHK;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    logic in_sift;
    assign in_sift = (r_state == S_SIFT_CHK) || (r_state == S_SIFT_R);

    // The single memory port never reads and writes in the same cycle
    `HSE_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, mem_we, !mem_re)
    // A sift position always lies inside the heap
    `HSE_ASSERT_IMP(a_pos_in_heap, i_clk, i_rst_n, in_sift, (r_pos != '0) && (r_pos <= r_hs))
    // The set never grows past capacity
    `HSE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT)
    // A final load always starts the sort
    `HSE_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, last_acc, r_state == S_START)
    // A finished sort hands out from the first value
    `HSE_ASSERT_IMP(a_sorted_rewind, i_clk, i_rst_n, $rose(r_sorted), r_rd_ptr == '0)
    // Output items come only out of the fetch state
    `HSE_ASSERT_IMP(a_out_from_fetch, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FETCH)

endmodule

@@ hdl/hse_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
// Read data holds while no read is issued.
module hse_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sim/heapsort_checker.sv @@
`timescale 1ns / 1ps

module heapsort_checker import hse_pkg::*; #(
    parameter int MAX_ITEMS = HSE_MAX_ITEMS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    // Current set as the engine should hold it; ascending once sorted.
    logic [VALUE_WIDTH-1:0] set_vals[$];
    int                     read_idx     = 0;
    bit                     set_sorted   = 1'b0;
    bit                     set_overflow = 1'b0;
    t_out_item              due_results[$];
    int                     fail_n       = 0;
    int                     pending_n    = 0;

    assign o_fail_count = fail_n;
    assign o_pending    = pending_n;

    // Advance the set state by one accepted item; queue the result of a fetch.
    function automatic void track_set(input t_in_item it);
        logic [VALUE_WIDTH-1:0] key;
        int                     b;
        t_out_item              res;
        if (it.kind == KIND_LOAD) begin
            // a load after a sorted set opens a new one
            if (set_sorted) begin
                set_vals.delete();
                read_idx     = 0;
                set_sorted   = 1'b0;
                set_overflow = 1'b0;
            end
            if (set_vals.size() < MAX_ITEMS)
                set_vals.push_back(it.value);
            else
                set_overflow = 1'b1;
            if (it.last) begin
                for (int a = 1; a < set_vals.size(); a++) begin
                    key = set_vals[a];
                    b   = a;
                    while (b > 0 && set_vals[b-1] > key) begin
                        set_vals[b] = set_vals[b-1];
                        b--;
                    end
                    set_vals[b] = key;
                end
                set_sorted = 1'b1;
                read_idx   = 0;
            end
        end else begin
            res = '0;
            if (set_sorted && read_idx < set_vals.size()) begin
                res.sorted_value = set_vals[read_idx];
                res.last_out     = (read_idx + 1 == set_vals.size());
                read_idx++;
            end else begin
                res.empty_res = 1'b1;
            end
            res.overflow = set_overflow;
            due_results.push_back(res);
        end
    endfunction

    function automatic void report(input string field, input logic [VALUE_WIDTH-1:0] want,
                                   input logic [VALUE_WIDTH-1:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        fail_n++;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                track_set(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_out_item);
                    fail_n++;
                end else begin
                    want = due_results.pop_front();
                    if (i_out_item.sorted_value !== want.sorted_value)
                        report("sorted_value", want.sorted_value, i_out_item.sorted_value);
                    if (i_out_item.last_out !== want.last_out)
                        report("last_out", VALUE_WIDTH'(want.last_out),
                               VALUE_WIDTH'(i_out_item.last_out));
                    if (i_out_item.empty_res !== want.empty_res)
                        report("empty_res", VALUE_WIDTH'(want.empty_res),
                               VALUE_WIDTH'(i_out_item.empty_res));
                    if (i_out_item.overflow !== want.overflow)
                        report("overflow", VALUE_WIDTH'(want.overflow),
                               VALUE_WIDTH'(i_out_item.overflow));
                end
            end
            pending_n = due_results.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the heapsort engine. The checker beside the block
// does all prediction and comparison; this module only drives items, throttles
// both channels and decides pass or fail.
module tb;
    import hse_pkg::*;

    // Generous cycle budget: sorts, worst-case gaps and stalls, several times over.
    localparam int RUN_LIMIT    = 2_000_000;
    localparam int RANDOM_ITEMS = 40;
    localparam int CALM_TAIL    = 20;
    localparam int OVF_READS    = 32;
    localparam int DRAIN_CYCLES = 50;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    // Calm turns all idling off; set for the tail of the run.
    bit        calm      = 1'b0;
    // Per-set chance of sender gaps; zero gives stretches with no gaps at all.
    int        gap_odds  = 0;
    int        items_sent = 0;

    heapsort_engine_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    heapsort_checker sort_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if it hangs anywhere.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: stall in bursts. The stall rate is re-rolled at the start
    // of each window so some windows run with no stalls at all.
    initial begin
        int stall_left;
        int stall_odds;
        int window;
        stall_left = 0;
        stall_odds = 0;
        window     = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (window == 0)
                stall_odds = $urandom_range(0, 2);
            window = (window + 1) % 256;
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!calm && stall_odds != 0 && $urandom_range(0, 7) == 0) begin
                // this cycle is the first of the burst
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Mix of extremes, small ranges (to force duplicates) and full-range values.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_WIDTH'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Drive one item and hold it until the engine takes it. Called at a falling
    // edge; returns at the falling edge after the handshake. An optional gap
    // first drops valid.
    task automatic send(input logic kind, input logic [VALUE_WIDTH-1:0] value,
                        input logic last);
        t_in_item it;
        it.kind  = kind;
        it.value = value;
        it.last  = last;
        if (!calm && gap_odds != 0 && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Fetch with random don't-care value and last bits.
    task automatic fetch();
        send(KIND_FETCH, $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int set_len;
        int n_fetch;
        int stop_at;
        bit drop_last;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: fetch on an empty engine.
        fetch();
        // One-value set at the top extreme, then read past its end.
        send(KIND_LOAD, '1, 1'b1);
        fetch();
        fetch();
        // Even-sized set with extremes and a duplicate; a fetch before the
        // sort must come back empty.
        send(KIND_LOAD, '0, 1'b0);
        send(KIND_LOAD, '1, 1'b0);
        fetch();
        send(KIND_LOAD, 32'd5, 1'b0);
        send(KIND_LOAD, 32'd5, 1'b1);
        repeat (4) fetch();
        // Odd set read only in part, then replaced by a new set.
        send(KIND_LOAD, 32'd7, 1'b0);
        send(KIND_LOAD, 32'd1, 1'b0);
        send(KIND_LOAD, 32'd7, 1'b1);
        fetch();
        send(KIND_LOAD, 32'h8000_0000, 1'b1);
        fetch();
        // Smallest even set: the compare-exchange and one pop order it.
        send(KIND_LOAD, 32'd9, 1'b0);
        send(KIND_LOAD, 32'd2, 1'b1);
        fetch();
        fetch();

        // Hold off the sender until every result is back.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        // Overflow: fill the store, drop one load, fetch while unsorted, then
        // end the set with a dropped last load and read the smallest values back.
        gap_odds = 1;
        repeat (HSE_MAX_ITEMS + 1) send(KIND_LOAD, pick_value(), 1'b0);
        fetch();
        send(KIND_LOAD, pick_value(), 1'b1);
        repeat (OVF_READS) fetch();

        // Random: mostly well-formed sets of random size and content, with
        // stray fetches, missing last flags and partial or over-long reads.
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            calm     = (items_sent > stop_at - CALM_TAIL);
            gap_odds = $urandom_range(0, 2);
            case ($urandom_range(0, 19))
                0:       set_len = $urandom_range(101, 300);
                1, 2, 3,
                4, 5:    set_len = $urandom_range(17, 100);
                default: set_len = $urandom_range(1, 16);
            endcase
            // keep the item count near its budget
            if (set_len > stop_at - items_sent)
                set_len = stop_at - items_sent;
            drop_last = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < set_len; i++) begin
                if ($urandom_range(0, 19) == 0)
                    fetch();
                send(KIND_LOAD, pick_value(), (i == set_len - 1) && !drop_last);
            end
            case ($urandom_range(0, 9))
                0, 1:    n_fetch = $urandom_range(0, set_len - 1);
                2, 3:    n_fetch = set_len + $urandom_range(1, 3);
                default: n_fetch = set_len;
            endcase
            repeat (n_fetch) fetch();
        end

        // Drain: wait out every expected result, then a short quiet period.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
